// ----- design/psaa_pkg.sv -----
`default_nettype none
package psaa_pkg;

  // Coordinate width of vertex_x and vertex_y.
  localparam int COORD_BITS = 24;

  // Edge operands are a sum or a difference of two coordinates.
  localparam int OP_W   = COORD_BITS + 1;
  // Product of an edge's sum operand and its difference operand.
  localparam int PROD_W = 2 * OP_W;
  localparam int SUM_W  = 64;
  localparam int NET_W  = 63;

  // Input stream data: vertex_x, then vertex_y, padded to whole bytes.
  localparam int S_DATA_W = ((2 * COORD_BITS + 7) / 8) * 8;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 64;
  localparam int M_USER_W = 1;

  // Bit positions in the input tuser.
  localparam int UserExclBit = 0;
  localparam int UserPendBit = 1;

  // Depth of the queue between front and back, a power of two.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Symmetric saturation limits of the sums.
  localparam logic signed [SUM_W-1:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 64'sh8000_0000_0000_0001;
  localparam logic signed [SUM_W:0]   SAT_POS = 65'sh0_7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [SUM_W:0]   SAT_NEG = 65'sh1_8000_0000_0000_0001;

  // One classified vertex: operands of the open edge and of the closing edge.
  // Operands are zero where the vertex brings no such edge.
  typedef struct packed {
    logic signed [OP_W-1:0] edge_sx;
    logic signed [OP_W-1:0] edge_dy;
    logic signed [OP_W-1:0] close_sx;
    logic signed [OP_W-1:0] close_dy;
    logic                   excl;
    logic                   send;
  } vtx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    ovf;
  } sat_res_t;

  function automatic sat_res_t sat_add(input logic signed [SUM_W-1:0] acc,
                                       input logic signed [SUM_W-1:0] term);
    logic signed [SUM_W:0] s;
    sat_res_t              r;
    s = $signed({acc[SUM_W-1], acc}) + $signed({term[SUM_W-1], term});
    if (s > SAT_POS) begin
      r.sum = SUM_MAX;
      r.ovf = 1'b1;
    end else if (s < SAT_NEG) begin
      r.sum = SUM_MIN;
      r.ovf = 1'b1;
    end else begin
      r.sum = s[SUM_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

  // floor(|s| / 2); the sums never reach -2^63, so |s| fits 63 bits.
  function automatic logic [SUM_W-3:0] half_mag(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0] m;
    m = s[SUM_W-1] ? SUM_W'(-s) : SUM_W'(s);
    return m[SUM_W-2:1];
  endfunction

endpackage
`default_nettype wire

// ----- design/psaa_front.sv -----
`default_nettype none
module psaa_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic signed [psaa_pkg::COORD_BITS-1:0] x_i,
  input  wire logic signed [psaa_pkg::COORD_BITS-1:0] y_i,
  input  wire logic                               excl_i,
  input  wire logic                               pend_i,
  input  wire logic                               send_i,
  output      logic                               push_valid_o,
  input  wire logic                               push_ready_i,
  output      psaa_pkg::vtx_t                     push_data_o
);

  localparam int CB = psaa_pkg::COORD_BITS;

  logic signed [CB-1:0] first_x_q, first_x_d;
  logic signed [CB-1:0] first_y_q, first_y_d;
  logic signed [CB-1:0] prev_x_q, prev_x_d;
  logic signed [CB-1:0] prev_y_q, prev_y_d;
  logic                 in_poly_q, in_poly_d;

  logic                 accept;
  logic                 closing;
  logic signed [CB-1:0] fx, fy;

  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;
  assign closing      = pend_i || send_i;

  // The first vertex of a polygon is its own start point.
  assign fx = in_poly_q ? first_x_q : x_i;
  assign fy = in_poly_q ? first_y_q : y_i;

  always_comb begin
    push_data_o.excl = excl_i;
    push_data_o.send = send_i;
    if (in_poly_q) begin
      push_data_o.edge_sx = $signed({prev_x_q[CB-1], prev_x_q}) + $signed({x_i[CB-1], x_i});
      push_data_o.edge_dy = $signed({prev_y_q[CB-1], prev_y_q}) - $signed({y_i[CB-1], y_i});
    end else begin
      push_data_o.edge_sx = '0;
      push_data_o.edge_dy = '0;
    end
    if (closing) begin
      push_data_o.close_sx = $signed({x_i[CB-1], x_i}) + $signed({fx[CB-1], fx});
      push_data_o.close_dy = $signed({y_i[CB-1], y_i}) - $signed({fy[CB-1], fy});
    end else begin
      push_data_o.close_sx = '0;
      push_data_o.close_dy = '0;
    end
  end

  always_comb begin
    first_x_d = first_x_q;
    first_y_d = first_y_q;
    prev_x_d  = prev_x_q;
    prev_y_d  = prev_y_q;
    in_poly_d = in_poly_q;
    if (accept) begin
      first_x_d = fx;
      first_y_d = fy;
      prev_x_d  = x_i;
      prev_y_d  = y_i;
      in_poly_d = !closing;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_x_q <= '0;
      first_y_q <= '0;
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      in_poly_q <= 1'b0;
    end else begin
      first_x_q <= first_x_d;
      first_y_q <= first_y_d;
      prev_x_q  <= prev_x_d;
      prev_y_q  <= prev_y_d;
      in_poly_q <= in_poly_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/psaa_queue.sv -----
`default_nettype none
module psaa_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output      logic           push_ready_o,
  input  wire psaa_pkg::vtx_t push_data_i,
  output      logic           pop_valid_o,
  input  wire logic           pop_ready_i,
  output      psaa_pkg::vtx_t pop_data_o
);

  psaa_pkg::vtx_t mem_q [psaa_pkg::QDEPTH];

  logic [psaa_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [psaa_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [psaa_pkg::QCNT_W-1:0] cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign push_ready_o = (cnt_q != psaa_pkg::QCNT_W'(psaa_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers wrap naturally since the depth is a power of two.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/psaa_back.sv -----
`default_nettype none
module psaa_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          pop_valid_i,
  output      logic                          pop_ready_o,
  input  wire psaa_pkg::vtx_t                pop_data_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [psaa_pkg::NET_W-1:0]    out_net_o,
  output      logic                          out_ovf_o
);

  localparam int PW = psaa_pkg::PROD_W;
  localparam int SW = psaa_pkg::SUM_W;

  // Multiply stage.
  logic                 m_v_q, m_v_d;
  logic signed [PW-1:0] m_edge_q, m_close_q;
  logic signed [PW-1:0] prod_edge, prod_close;
  logic                 m_excl_q, m_send_q;

  // Accumulators.
  logic signed [SW-1:0] inc_q, inc_d;
  logic signed [SW-1:0] exc_q, exc_d;
  logic                 sat_q, sat_d;

  // Finished set, waiting for the area calculation.
  logic                 f_v_q, f_v_d;
  logic signed [SW-1:0] f_inc_q, f_exc_q;
  logic                 f_sat_q;

  // Output register.
  logic                           o_v_q, o_v_d;
  logic [psaa_pkg::NET_W-1:0]     o_net_q;
  logic                           o_ovf_q;

  logic                 o_ready, f_ready, acc_take, m_adv, m_load;
  logic signed [SW-1:0] target, term_edge, term_close;
  psaa_pkg::sat_res_t   r1, r2;
  logic [psaa_pkg::NET_W-1:0] net_full;

  assign o_ready     = !o_v_q || out_ready_i;
  assign f_ready     = !f_v_q || o_ready;
  assign acc_take    = m_v_q && (!m_send_q || f_ready);
  assign m_adv       = !m_v_q || acc_take;
  assign pop_ready_o = m_adv;
  assign m_load      = pop_valid_i && m_adv;

  assign prod_edge  = $signed(pop_data_i.edge_sx) * $signed(pop_data_i.edge_dy);
  assign prod_close = $signed(pop_data_i.close_sx) * $signed(pop_data_i.close_dy);

  assign term_edge  = $signed({{(SW-PW){m_edge_q[PW-1]}}, m_edge_q});
  assign term_close = $signed({{(SW-PW){m_close_q[PW-1]}}, m_close_q});
  assign target     = m_excl_q ? exc_q : inc_q;

  // The open edge is added before the closing edge, each one saturating.
  assign r1 = psaa_pkg::sat_add(target, term_edge);
  assign r2 = psaa_pkg::sat_add(r1.sum, term_close);

  always_comb begin
    inc_d = inc_q;
    exc_d = exc_q;
    sat_d = sat_q;
    if (acc_take) begin
      if (m_send_q) begin
        inc_d = '0;
        exc_d = '0;
        sat_d = 1'b0;
      end else begin
        if (m_excl_q) begin
          exc_d = r2.sum;
        end else begin
          inc_d = r2.sum;
        end
        sat_d = sat_q || r1.ovf || r2.ovf;
      end
    end
  end

  assign m_v_d = m_adv ? pop_valid_i : m_v_q;
  assign f_v_d = f_ready ? (acc_take && m_send_q) : f_v_q;
  assign o_v_d = o_ready ? f_v_q : o_v_q;

  assign net_full = {1'b0, psaa_pkg::half_mag(f_inc_q)} -
                    {1'b0, psaa_pkg::half_mag(f_exc_q)};

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      m_edge_q  <= prod_edge;
      m_close_q <= prod_close;
      m_excl_q  <= pop_data_i.excl;
      m_send_q  <= pop_data_i.send;
    end
    if (f_ready && acc_take && m_send_q) begin
      f_inc_q <= m_excl_q ? inc_q : r2.sum;
      f_exc_q <= m_excl_q ? r2.sum : exc_q;
      f_sat_q <= sat_q || r1.ovf || r2.ovf;
    end
    if (o_ready && f_v_q) begin
      o_net_q <= net_full;
      o_ovf_q <= f_sat_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      f_v_q <= 1'b0;
      o_v_q <= 1'b0;
      inc_q <= '0;
      exc_q <= '0;
      sat_q <= 1'b0;
    end else begin
      m_v_q <= m_v_d;
      f_v_q <= f_v_d;
      o_v_q <= o_v_d;
      inc_q <= inc_d;
      exc_q <= exc_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_net_o   = o_net_q;
  assign out_ovf_o   = o_ovf_q;

endmodule
`default_nettype wire

// ----- design/polygon_set_area_accumulator_top.sv -----
// Throughput: one vertex per cycle, sustained, with both output and input flowing.
// The area of a set appears on m_axis_tvalid_o once the set's last vertex has passed
// through the queue write, multiply, accumulate and area subtract registers, in order.
// A four-entry queue decouples vertex intake from the multiply and accumulate path.
// Reset (rst_ni low, asynchronous) clears both sums, the overflow flag, the open
// polygon and all valid flags at once; there is no clearing pass.
`default_nettype none
module polygon_set_area_accumulator_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Vertex stream.
  input  wire logic                            s_axis_tvalid_i,
  output      logic                            s_axis_tready_o,
  // Fields from bit 0 up: vertex_x, vertex_y.
  input  wire logic [psaa_pkg::S_DATA_W-1:0]   s_axis_tdata_i,
  // Fields from bit 0 up: is_exclusion, polygon_end.
  input  wire logic [psaa_pkg::S_USER_W-1:0]   s_axis_tuser_i,
  // set_end: last vertex of the whole polygon set.
  input  wire logic                            s_axis_tlast_i,
  // Area result stream.
  output      logic                            m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // Fields from bit 0 up: net_area (63 bits, signed), one zero pad bit.
  output      logic [psaa_pkg::M_DATA_W-1:0]   m_axis_tdata_o,
  // Fields from bit 0 up: overflow.
  output      logic [psaa_pkg::M_USER_W-1:0]   m_axis_tuser_o
);

  localparam int CB = psaa_pkg::COORD_BITS;

  // The front end tracks the open polygon and turns every vertex request into
  // the operand pairs of up to two edges: the edge from the previous vertex,
  // and, when the polygon or the set ends, the closing edge back to the first
  // vertex. Edges that do not exist are given zero operands and add nothing.
  logic           push_valid, push_ready;
  psaa_pkg::vtx_t push_data;
  logic           pop_valid, pop_ready;
  psaa_pkg::vtx_t pop_data;

  logic [psaa_pkg::NET_W-1:0] net;
  logic                       ovf;

  psaa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .x_i          ($signed(s_axis_tdata_i[CB-1:0])),
    .y_i          ($signed(s_axis_tdata_i[2*CB-1:CB])),
    .excl_i       (s_axis_tuser_i[psaa_pkg::UserExclBit]),
    .pend_i       (s_axis_tuser_i[psaa_pkg::UserPendBit]),
    .send_i       (s_axis_tlast_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // The queue lets vertex intake continue while a finished area waits at the
  // output, and lets the back end drain while the source pauses.
  psaa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // The back end forms both edge products in one stage, adds them in order to
  // the inclusion or exclusion sum with saturation, and on the set's last
  // vertex hands the sums to the area subtract and clears them. Vertices wait
  // on the output side only when a set's last vertex finds two finished areas
  // still held ahead of it.
  psaa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_net_o   (net),
    .out_ovf_o   (ovf)
  );

  assign m_axis_tdata_o = {{(psaa_pkg::M_DATA_W - psaa_pkg::NET_W){1'b0}}, net};
  assign m_axis_tuser_o = ovf;

endmodule
`default_nettype wire
